// File: hdl/lsep_pkg.sv
// ----------------------------------------------------------------------------
// lsep_pkg: shared types and constants of the line sensor error PID block
// Holds the sensor count, the scaling constants, the register codes, the
// configuration bundle and the ordered rules that turn sensor flags into an
// error value.
// ----------------------------------------------------------------------------
package lsep_pkg;

  localparam int NUM_SENSORS     = 7;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int LOW_MARK_RESET  = 2000;
  localparam int LOW_MARK_MIN_W  = 11;
  localparam int OUT_LOW         = 200;
  localparam int OUT_HIGH        = 800;
  localparam int OUT_SPAN        = OUT_HIGH - OUT_LOW;
  localparam int QUOT_BITS       = 10;
  localparam int SUM_LIMIT       = 32767;
  localparam int CUT_RESET       = 500;
  localparam int CUT_W           = 10;
  localparam int GAIN_W          = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 10;
  localparam int LEVEL_W         = 10;
  localparam int ERR_W           = 4;
  localparam int DRIVE_W         = 16;
  localparam int FIFO_DEPTH      = 2;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUT_LEVEL = 2'd0,
    CFG_GAIN_P    = 2'd1,
    CFG_GAIN_I    = 2'd2,
    CFG_GAIN_D    = 2'd3
  } cfg_idx_e;

  // Item kinds as classified by the front end.
  typedef enum logic {
    OP_CALIBRATE = 1'b0,
    OP_STEP      = 1'b1
  } op_e;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_KICK,
    S_WAIT,
    S_ERR,
    S_MUL,
    S_DRIVE
  } back_state_e;

  typedef struct packed {
    logic [CUT_W-1:0]  cut_level;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
  } cfg_t;

  // Ordered adjacent-pair rules; the first rule that matches wins.
  function automatic logic signed [ERR_W-1:0] line_position(
    input logic [NUM_SENSORS-1:0] on,
    input logic [NUM_SENSORS-1:0] off
  );
    logic signed [ERR_W-1:0] e;
    e = 4'sd0;
    if (on[0] && off[1])      e = -4'sd6;
    else if (on[6] && off[5]) e = 4'sd6;
    else if (on[0] && on[1])  e = -4'sd5;
    else if (on[6] && on[5])  e = 4'sd5;
    else if (on[1] && off[2]) e = -4'sd4;
    else if (on[5] && off[4]) e = 4'sd4;
    else if (on[1] && on[2])  e = -4'sd3;
    else if (on[5] && on[4])  e = 4'sd3;
    else if (on[2] && off[3]) e = -4'sd2;
    else if (on[4] && off[3]) e = 4'sd2;
    else if (on[2] && on[3])  e = -4'sd1;
    else if (on[4] && on[3])  e = 4'sd1;
    return e;
  endfunction

endpackage

// File: hdl/lsep_if.sv
// ----------------------------------------------------------------------------
// lsep_in_if / lsep_out_if: valid-ready channels of the block
// The input channel carries the item kind and one raw sample per sensor; the
// output channel carries the line error and the PID drive.
// ----------------------------------------------------------------------------
interface lsep_in_if import lsep_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [SAMPLE_BITS-1:0] sample_0;
  logic [SAMPLE_BITS-1:0] sample_1;
  logic [SAMPLE_BITS-1:0] sample_2;
  logic [SAMPLE_BITS-1:0] sample_3;
  logic [SAMPLE_BITS-1:0] sample_4;
  logic [SAMPLE_BITS-1:0] sample_5;
  logic [SAMPLE_BITS-1:0] sample_6;

  modport source (output valid, func, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, sample_6, input ready);
  modport sink (input valid, func, sample_0, sample_1, sample_2, sample_3,
                sample_4, sample_5, sample_6, output ready);
endinterface

interface lsep_out_if;
  logic               valid;
  logic               ready;
  logic signed [3:0]  line_error;
  logic signed [15:0] drive;

  modport source (output valid, line_error, drive, input ready);
  modport sink (input valid, line_error, drive, output ready);
endinterface

// File: hdl/lsep_front.sv
// ----------------------------------------------------------------------------
// lsep_front: input acceptance and item queue
// Accepts transactions into a two-entry queue, classifies each as a
// calibrate or a step item and presents the oldest one to the back end.
// ----------------------------------------------------------------------------
module lsep_front import lsep_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  lsep_in_if.sink                                 in_if,
  output logic                                    item_valid_o,
  output op_e                                     item_op_o,
  output logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] item_samples_o,
  input  logic                                    item_pop_i
);

  localparam int ITEM_W = 1 + NUM_SENSORS * SAMPLE_BITS;
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

  logic [ITEM_W-1:0] mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push, pop;
  logic [ITEM_W-1:0] wr_item, head;

  assign in_if.ready = (count_q != CNT_W'(FIFO_DEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign pop         = item_pop_i && (count_q != '0);

  // Pack the incoming transaction, with the item kind bit on top.
  assign wr_item = {in_if.func, in_if.sample_6, in_if.sample_5, in_if.sample_4,
                    in_if.sample_3, in_if.sample_2, in_if.sample_1,
                    in_if.sample_0};

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push ? PTR_W'((32'(wr_ptr_q) + 1) % FIFO_DEPTH) : wr_ptr_q;
    rd_ptr_d = pop ? PTR_W'((32'(rd_ptr_q) + 1) % FIFO_DEPTH) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item;
    end
  end

  assign head           = mem_q[rd_ptr_q];
  assign item_valid_o   = (count_q != '0);
  assign item_op_o      = head[ITEM_W-1] ? OP_STEP : OP_CALIBRATE;
  assign item_samples_o = head[ITEM_W-2:0];

endmodule

// File: hdl/lsep_div.sv
// ----------------------------------------------------------------------------
// lsep_div: shared restoring divider for sample scaling
// Divides an unsigned numerator by an unsigned span, one quotient bit per
// cycle, and flags quotients that do not fit the quotient width.
// ----------------------------------------------------------------------------
module lsep_div import lsep_pkg::*; #(
  parameter int SW = 11,
  parameter int MW = 21
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MW-1:0]        num_i,
  input  logic [SW-1:0]        den_i,
  output logic                 done_o,
  output logic                 over_o,
  output logic [QUOT_BITS-1:0] quot_o
);

  localparam int CW = $clog2(QUOT_BITS + 1);

  logic                 busy_q, done_q, over_q;
  logic [CW-1:0]        cnt_q;
  logic [SW-1:0]        rem_q, den_q;
  logic [QUOT_BITS-1:0] low_q;
  logic [SW:0]          trial;
  logic [SW:0]          trial_sub;
  logic                 over_now;

  // Quotient overflows when the numerator reaches the span shifted by the
  // quotient width.
  assign over_now  = {1'b0, num_i} >= ((MW + 1)'(den_i) << QUOT_BITS);
  assign trial     = {rem_q, low_q[QUOT_BITS-1]};
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !over_now;
        done_q <= over_now;
        cnt_q  <= CW'(QUOT_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and numerator bits shift left, quotient bits enter.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      over_q <= over_now;
      den_q  <= den_i;
      rem_q  <= SW'(num_i >> QUOT_BITS);
      low_q  <= num_i[QUOT_BITS-1:0];
    end else if (busy_q) begin
      if (!trial_sub[SW]) begin
        rem_q <= trial_sub[SW-1:0];
        low_q <= {low_q[QUOT_BITS-2:0], 1'b1};
      end else begin
        rem_q <= trial[SW-1:0];
        low_q <= {low_q[QUOT_BITS-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign over_o = over_q;
  assign quot_o = low_q;

endmodule

// File: hdl/lsep_back.sv
// ----------------------------------------------------------------------------
// lsep_back: calibration, scaling, error rules and PID
// Carries out queued items: calibrate items widen the stored extremes, step
// items scale each sensor through the shared divider, derive the line error
// and run the PID update into the output register.
// ----------------------------------------------------------------------------
module lsep_back import lsep_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  cfg_t                                    cfg_i,
  input  logic                                    item_valid_i,
  input  op_e                                     item_op_i,
  input  logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] item_samples_i,
  output logic                                    item_pop_o,
  lsep_out_if.source                              out_if
);

  localparam int LW = (SAMPLE_BITS > LOW_MARK_MIN_W) ? SAMPLE_BITS : LOW_MARK_MIN_W;
  localparam int DW = LW + 1;
  localparam int MW = LW + QUOT_BITS;
  localparam int KW = $clog2(NUM_SENSORS);
  localparam int SUM_W  = 16;
  localparam int PP_W   = GAIN_W + ERR_W + 1;
  localparam int PI_W   = GAIN_W + SUM_W + 1;
  localparam int PD_W   = GAIN_W + ERR_W + 2;
  localparam int TOT_W  = PI_W + 2;

  back_state_e state_q, state_d;

  logic [LW-1:0]          low_q  [NUM_SENSORS];
  logic [SAMPLE_BITS-1:0] high_q [NUM_SENSORS];
  logic [KW-1:0]          k_q;
  logic [NUM_SENSORS-1:0] on_q, off_q;
  logic [MW-1:0]          num_q;
  logic [LW-1:0]          den_q;
  logic                   trivial_q;

  logic signed [SUM_W-1:0] sum_q;
  logic signed [ERR_W-1:0] last_q, e_q;
  logic signed [ERR_W:0]   d_q;
  logic signed [PP_W-1:0]  pp_q;
  logic signed [PI_W-1:0]  pi_q;
  logic signed [PD_W-1:0]  pd_q;

  logic                    out_valid_q;
  logic signed [ERR_W-1:0]   out_err_q;
  logic signed [DRIVE_W-1:0] out_drive_q;

  // Sequencer controls.
  logic cal_en, prep_en, kick, sens_en, err_en, mul_en, drive_en;

  // Divider results.
  logic                 div_done, div_over;
  logic [QUOT_BITS-1:0] div_quot;

  // Per-sensor preparation for the current sensor.
  logic [SAMPLE_BITS-1:0] x_cur;
  logic signed [DW-1:0]   diff, span;
  logic [LW-1:0]          diff_mag, span_mag;

  assign x_cur    = item_samples_i[k_q];
  assign diff     = $signed(DW'(x_cur)) - $signed(DW'(low_q[k_q]));
  assign span     = $signed(DW'(high_q[k_q])) - $signed(DW'(low_q[k_q]));
  assign diff_mag = diff[DW-1] ? LW'(-diff) : LW'(diff);
  assign span_mag = span[DW-1] ? LW'(-span) : LW'(span);

  // Normalized level of the current sensor once the divider finishes.
  logic [LEVEL_W-1:0] level;
  always_comb begin
    if (trivial_q) begin
      level = LEVEL_W'(OUT_LOW);
    end else if (div_over || (div_quot > QUOT_BITS'(OUT_SPAN))) begin
      level = LEVEL_W'(OUT_HIGH);
    end else begin
      level = LEVEL_W'(OUT_LOW) + LEVEL_W'(div_quot);
    end
  end

  // Error rules and integral update.
  logic signed [ERR_W-1:0] e_new;
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] sum_new;
  assign e_new   = line_position(on_q, off_q);
  assign sum_ext = $signed({sum_q[SUM_W-1], sum_q}) + (SUM_W + 1)'(e_new);
  always_comb begin
    if (e_new == '0) begin
      sum_new = '0;
    end else if (sum_ext > (SUM_W + 1)'(SUM_LIMIT)) begin
      sum_new = SUM_W'(SUM_LIMIT);
    end else if (sum_ext < -(SUM_W + 1)'(SUM_LIMIT)) begin
      sum_new = -SUM_W'(SUM_LIMIT);
    end else begin
      sum_new = sum_ext[SUM_W-1:0];
    end
  end

  // Drive sum and saturation.
  logic signed [TOT_W-1:0]   total;
  logic signed [DRIVE_W-1:0] drive_sat;
  assign total = TOT_W'(pp_q) + TOT_W'(pi_q) + TOT_W'(pd_q);
  always_comb begin
    if (total > TOT_W'(32767)) begin
      drive_sat = 16'sh7FFF;
    end else if (total < -TOT_W'(32768)) begin
      drive_sat = 16'sh8000;
    end else begin
      drive_sat = total[DRIVE_W-1:0];
    end
  end

  // Next state and controls.
  always_comb begin
    state_d    = state_q;
    cal_en     = 1'b0;
    prep_en    = 1'b0;
    kick       = 1'b0;
    sens_en    = 1'b0;
    err_en     = 1'b0;
    mul_en     = 1'b0;
    drive_en   = 1'b0;
    item_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          if (item_op_i == OP_CALIBRATE) begin
            cal_en     = 1'b1;
            item_pop_o = 1'b1;
          end else begin
            state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        prep_en = 1'b1;
        state_d = S_KICK;
      end
      S_KICK: begin
        kick    = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          sens_en = 1'b1;
          state_d = (k_q == KW'(NUM_SENSORS - 1)) ? S_ERR : S_PREP;
        end
      end
      S_ERR: begin
        err_en  = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        mul_en  = 1'b1;
        state_d = S_DRIVE;
      end
      S_DRIVE: begin
        if (!out_valid_q || out_if.ready) begin
          drive_en   = 1'b1;
          item_pop_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Stored extremes: a lower sample widens the minimum, else a higher one
  // widens the maximum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        low_q[i]  <= LW'(LOW_MARK_RESET);
        high_q[i] <= '0;
      end
    end else if (cal_en) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (LW'(item_samples_i[i]) < low_q[i]) begin
          low_q[i] <= LW'(item_samples_i[i]);
        end else if (item_samples_i[i] > high_q[i]) begin
          high_q[i] <= item_samples_i[i];
        end
      end
    end
  end

  // PID state and sensor counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      last_q <= '0;
      k_q    <= '0;
    end else begin
      if (sens_en) begin
        k_q <= (k_q == KW'(NUM_SENSORS - 1)) ? '0 : k_q + 1'b1;
      end
      if (err_en) begin
        sum_q  <= sum_new;
        last_q <= e_new;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (prep_en) begin
      num_q     <= MW'(diff_mag) * MW'(OUT_SPAN);
      den_q     <= span_mag;
      trivial_q <= (span == '0) || (diff == '0) || (diff[DW-1] != span[DW-1]);
    end
    if (sens_en) begin
      on_q[k_q]  <= (level <= cfg_i.cut_level);
      off_q[k_q] <= (level >= cfg_i.cut_level);
    end
    if (err_en) begin
      e_q <= e_new;
      d_q <= (ERR_W + 1)'(e_new) - (ERR_W + 1)'(last_q);
    end
    if (mul_en) begin
      pp_q <= $signed({1'b0, cfg_i.gain_p}) * e_q;
      pi_q <= $signed({1'b0, cfg_i.gain_i}) * sum_q;
      pd_q <= $signed({1'b0, cfg_i.gain_d}) * d_q;
    end
    if (drive_en) begin
      out_err_q   <= e_q;
      out_drive_q <= drive_sat;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (drive_en) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.line_error = out_err_q;
  assign out_if.drive      = out_drive_q;

  lsep_div #(
    .SW (LW),
    .MW (MW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (kick),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .over_o  (div_over),
    .quot_o  (div_quot)
  );

  // A pending result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_en |-> (!out_valid_q || out_if.ready))
    else $error("result register overwritten");

  // The divider is only started after the operands were prepared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    kick |-> $past(prep_en))
    else $error("divider started without operands");

  // The integral stays inside its saturation range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q != 16'sh8000)
    else $error("integral out of range");

  // A queued item is only released when it has been carried out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> (cal_en || drive_en))
    else $error("item released early");

endmodule

// File: hdl/line_sensor_error_pid_top.sv
// Sequencing: a calibrate item is carried out in the idle state; a step item
// runs prepare, kick and wait for each of the seven sensors in turn through
// the shared bit-serial divider (no bit steps when a quotient overflows), then
// error, multiply and drive into the output register, drive waiting while a
// result is still pending. Items are carried out one at a time.
// Reset restores extremes (2000, 0), integral, last error, queue and registers.
// ----------------------------------------------------------------------------
// line_sensor_error_pid_top: line sensor array error and PID corrector
// Holds the configuration registers and joins the input queue to the
// calibration, scaling and PID back end.
// ----------------------------------------------------------------------------
module line_sensor_error_pid_top import lsep_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lsep_in_if.sink               in_if,
  lsep_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;

  logic                                    item_valid, item_pop;
  op_e                                     item_op;
  logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] item_samples;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cut_level <= CUT_W'(CUT_RESET);
      cfg_q.gain_p    <= '0;
      cfg_q.gain_i    <= '0;
      cfg_q.gain_d    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CUT_LEVEL: cfg_q.cut_level <= cfg_data_i[CUT_W-1:0];
        CFG_GAIN_P:    cfg_q.gain_p    <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_I:    cfg_q.gain_i    <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_D:    cfg_q.gain_d    <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  lsep_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_if          (in_if),
    .item_valid_o   (item_valid),
    .item_op_o      (item_op),
    .item_samples_o (item_samples),
    .item_pop_i     (item_pop)
  );

  lsep_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_valid_i   (item_valid),
    .item_op_i      (item_op),
    .item_samples_i (item_samples),
    .item_pop_o     (item_pop),
    .out_if         (out_if)
  );

endmodule
